FILE: rtl/core/lrfb_pkg.sv
// ----------------------------------------------------------------------------
// lrfb_pkg: shared types and constants for the line rasterizer
// Pixel formats, register map, command codes and reset values used by the
// stepper, the framebuffer write former and the configuration registers.
// ----------------------------------------------------------------------------
package lrfb_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF  = 12;
    localparam int STRIDE_BITS_DEF = 14;

    // Fixed result widths
    localparam int ADDR_BITS  = 26;
    localparam int VALUE_BITS = 24;
    localparam int COUNT_BITS = 3;

    // Configuration port
    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;

    // Request commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Pixel formats
    typedef enum logic [1:0] {
        FMT_RGB565   = 2'd0,
        FMT_RGB888   = 2'd1,
        FMT_XRGB8888 = 2'd2,
        FMT_NONE     = 2'd3
    } fmt_t;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_FORMAT = 3'd0,
        REG_STRIDE = 3'd1,
        REG_RED    = 3'd2,
        REG_GREEN  = 3'd3,
        REG_BLUE   = 3'd4
    } reg_idx_t;

    // Drawing color
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // Reset values
    localparam fmt_t       FORMAT_RST = FMT_XRGB8888;
    localparam logic [7:0] RED_RST    = 8'd0;
    localparam logic [7:0] GREEN_RST  = 8'd255;
    localparam logic [7:0] BLUE_RST   = 8'd0;

    // Bytes written per format
    localparam logic [COUNT_BITS-1:0] BYTES_RGB565   = 3'd2;
    localparam logic [COUNT_BITS-1:0] BYTES_RGB888   = 3'd3;
    localparam logic [COUNT_BITS-1:0] BYTES_XRGB8888 = 3'd4;
    localparam logic [COUNT_BITS-1:0] BYTES_NONE     = 3'd0;

endpackage

FILE: rtl/core/lrfb_if.sv
// ----------------------------------------------------------------------------
// lrfb_if: request and pixel channels of the line rasterizer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------

// Draw requests: load endpoints or step one pixel
interface lrfb_draw_if #(
    parameter int COORD_BITS = lrfb_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (
        output valid, cmd, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

// Framebuffer pixel writes
interface lrfb_pixel_if #(
    parameter int COORD_BITS = lrfb_pkg::COORD_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic [COORD_BITS-1:0]            pixel_x;
    logic [COORD_BITS-1:0]            pixel_y;
    logic [lrfb_pkg::ADDR_BITS-1:0]   byte_address;
    logic [lrfb_pkg::VALUE_BITS-1:0]  pixel_value;
    logic [lrfb_pkg::COUNT_BITS-1:0]  byte_count;
    logic                             last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, byte_address, pixel_value, byte_count,
               last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, byte_address, pixel_value, byte_count,
               last_pixel,
        output ready
    );
endinterface

FILE: rtl/core/lrfb_regs.sv
// ----------------------------------------------------------------------------
// lrfb_regs: configuration registers
// APB-style register file holding pixel format, line stride and color.
// ----------------------------------------------------------------------------
module lrfb_regs #(
    parameter int STRIDE_BITS = lrfb_pkg::STRIDE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrfb_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [lrfb_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [lrfb_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready,
    output lrfb_pkg::fmt_t                       format,
    output logic [STRIDE_BITS-1:0]               stride,
    output lrfb_pkg::color_t                     color
);
    import lrfb_pkg::*;

    fmt_t                   format_reg;
    logic [STRIDE_BITS-1:0] stride_reg;
    color_t                 color_reg;
    reg_idx_t               idx;
    logic                   wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg      <= FORMAT_RST;
            stride_reg      <= '0;
            color_reg.red   <= RED_RST;
            color_reg.green <= GREEN_RST;
            color_reg.blue  <= BLUE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FORMAT: format_reg      <= fmt_t'(pwdata[1:0]);
                REG_STRIDE: stride_reg      <= pwdata[STRIDE_BITS-1:0];
                REG_RED:    color_reg.red   <= pwdata[7:0];
                REG_GREEN:  color_reg.green <= pwdata[7:0];
                REG_BLUE:   color_reg.blue  <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_FORMAT: prdata = PDATA_BITS'(format_reg);
            REG_STRIDE: prdata = PDATA_BITS'(stride_reg);
            REG_RED:    prdata = PDATA_BITS'(color_reg.red);
            REG_GREEN:  prdata = PDATA_BITS'(color_reg.green);
            REG_BLUE:   prdata = PDATA_BITS'(color_reg.blue);
            default:    prdata = '0;
        endcase
    end

    assign format = format_reg;
    assign stride = stride_reg;
    assign color  = color_reg;

endmodule

FILE: rtl/core/lrfb_stepper.sv
// ----------------------------------------------------------------------------
// lrfb_stepper: Bresenham line setup and stepping
// Registers each request, sets up a line on load or advances it by one pixel
// on step, and holds the pixel coordinates for the write former.
// ----------------------------------------------------------------------------
module lrfb_stepper #(
    parameter int COORD_BITS = lrfb_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lrfb_draw_if.sink             draw,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output logic [COORD_BITS-1:0] pix_x,
    output logic [COORD_BITS-1:0] pix_y,
    output logic                  pix_last
);
    import lrfb_pkg::*;

    localparam int TW_BITS  = COORD_BITS + 1;   // twice a delta
    localparam int DEC_BITS = COORD_BITS + 3;   // signed decision term

    // Input register
    logic                  s0_valid_reg;
    logic                  s0_cmd_reg;
    logic [COORD_BITS-1:0] s0_sx_reg, s0_sy_reg, s0_ex_reg, s0_ey_reg;

    // Line state
    logic                       active_reg,    active_next;
    logic                       steep_reg,     steep_next;
    logic [COORD_BITS-1:0]      major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0]      major_end_reg, major_end_next;
    logic [COORD_BITS-1:0]      minor_pos_reg, minor_pos_next;
    logic                       minor_neg_reg, minor_neg_next;
    logic signed [DEC_BITS-1:0] dec_reg,       dec_next;
    logic [TW_BITS-1:0]         tmaj_reg,      tmaj_next;
    logic [TW_BITS-1:0]         tmin_reg,      tmin_next;

    // Pixel register
    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic                  s1_last_reg;

    logic                  s1_ready;
    logic                  fire0;
    logic                  is_step;
    logic                  emit;
    logic                  at_end;

    // Setup terms
    logic [COORD_BITS-1:0] adx, ady, dmaj, dmin;
    logic                  steep;
    logic [COORD_BITS-1:0] ma0, ma1, mi0, mi1;
    logic                  swap;
    logic [COORD_BITS-1:0] mstart, mend, nstart, nend;
    logic                  dec_pos;

    // Handshake
    assign s1_ready   = !s1_valid_reg || pix_ready;
    assign fire0      = s0_valid_reg && s1_ready;
    assign draw.ready = !s0_valid_reg || s1_ready;
    assign is_step    = (s0_cmd_reg == CMD_STEP);
    assign emit       = fire0 && is_step && active_reg;
    assign at_end     = (major_pos_reg == major_end_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (draw.valid && draw.ready)
            s0_valid_reg <= 1'b1;
        else if (fire0)
            s0_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (draw.valid && draw.ready)
        begin
            s0_cmd_reg <= draw.cmd;
            s0_sx_reg  <= draw.start_x;
            s0_sy_reg  <= draw.start_y;
            s0_ex_reg  <= draw.end_x;
            s0_ey_reg  <= draw.end_y;
        end
    end

    // Line setup: major axis, ordering along it, minor direction
    always_comb
    begin
        adx    = (s0_ex_reg >= s0_sx_reg) ? s0_ex_reg - s0_sx_reg : s0_sx_reg - s0_ex_reg;
        ady    = (s0_ey_reg >= s0_sy_reg) ? s0_ey_reg - s0_sy_reg : s0_sy_reg - s0_ey_reg;
        steep  = (ady >= adx);
        dmaj   = steep ? ady : adx;
        dmin   = steep ? adx : ady;
        ma0    = steep ? s0_sy_reg : s0_sx_reg;
        ma1    = steep ? s0_ey_reg : s0_ex_reg;
        mi0    = steep ? s0_sx_reg : s0_sy_reg;
        mi1    = steep ? s0_ex_reg : s0_ey_reg;
        swap   = (ma0 > ma1);
        mstart = swap ? ma1 : ma0;
        mend   = swap ? ma0 : ma1;
        nstart = swap ? mi1 : mi0;
        nend   = swap ? mi0 : mi1;
    end

    assign dec_pos = !dec_reg[DEC_BITS-1] && (dec_reg != '0);

    // Next line state
    always_comb
    begin
        active_next    = active_reg;
        steep_next     = steep_reg;
        major_pos_next = major_pos_reg;
        major_end_next = major_end_reg;
        minor_pos_next = minor_pos_reg;
        minor_neg_next = minor_neg_reg;
        dec_next       = dec_reg;
        tmaj_next      = tmaj_reg;
        tmin_next      = tmin_reg;
        if (fire0 && !is_step)
        begin
            active_next    = 1'b1;
            steep_next     = steep;
            major_pos_next = mstart;
            major_end_next = mend;
            minor_pos_next = nstart;
            minor_neg_next = (nend < nstart);
            tmaj_next      = {dmaj, 1'b0};
            tmin_next      = {dmin, 1'b0};
            dec_next       = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
        end
        else if (emit)
        begin
            if (at_end)
                active_next = 1'b0;
            else
            begin
                if (dec_pos)
                    minor_pos_next = minor_neg_reg ? minor_pos_reg - COORD_BITS'(1)
                                                   : minor_pos_reg + COORD_BITS'(1);
                dec_next = dec_reg + $signed({2'b00, tmin_reg})
                         - (dec_pos ? $signed({2'b00, tmaj_reg}) : DEC_BITS'(0));
                major_pos_next = major_pos_reg + COORD_BITS'(1);
            end
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            steep_reg     <= 1'b0;
            major_pos_reg <= '0;
            major_end_reg <= '0;
            minor_pos_reg <= '0;
            minor_neg_reg <= 1'b0;
            dec_reg       <= '0;
            tmaj_reg      <= '0;
            tmin_reg      <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            steep_reg     <= steep_next;
            major_pos_reg <= major_pos_next;
            major_end_reg <= major_end_next;
            minor_pos_reg <= minor_pos_next;
            minor_neg_reg <= minor_neg_next;
            dec_reg       <= dec_next;
            tmaj_reg      <= tmaj_next;
            tmin_reg      <= tmin_next;
        end
    end

    // Pixel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_x_reg    <= steep_reg ? minor_pos_reg : major_pos_reg;
            s1_y_reg    <= steep_reg ? major_pos_reg : minor_pos_reg;
            s1_last_reg <= at_end;
        end
    end

    assign pix_valid = s1_valid_reg;
    assign pix_x     = s1_x_reg;
    assign pix_y     = s1_y_reg;
    assign pix_last  = s1_last_reg;

`ifndef SYNTHESIS
    // A consumed load always leaves a running line
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire0 && !is_step) |=> active_reg)
        else $error("load did not start a line");

    // The last pixel ends the line
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && at_end) |=> !active_reg)
        else $error("line still active after its last pixel");

    // Stepping never runs past the end point
    a_within_end: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (major_pos_reg <= major_end_reg))
        else $error("major position passed the line end");
`endif

endmodule

FILE: rtl/core/lrfb_writer.sv
// ----------------------------------------------------------------------------
// lrfb_writer: framebuffer write former
// Turns a pixel position into a byte address, packed color and byte count,
// held in the output register until taken.
// ----------------------------------------------------------------------------
module lrfb_writer #(
    parameter int COORD_BITS  = lrfb_pkg::COORD_BITS_DEF,
    parameter int STRIDE_BITS = lrfb_pkg::STRIDE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_ready,
    input  logic [COORD_BITS-1:0]  pix_x,
    input  logic [COORD_BITS-1:0]  pix_y,
    input  logic                   pix_last,
    input  lrfb_pkg::fmt_t         format,
    input  logic [STRIDE_BITS-1:0] stride,
    input  lrfb_pkg::color_t       color,
    lrfb_pixel_if.source           pixel
);
    import lrfb_pkg::*;

    localparam int COL_BITS = COORD_BITS + 2;
    localparam int ROW_BITS = COORD_BITS + STRIDE_BITS;
    localparam int SUM_BITS = (ROW_BITS + 1 > ADDR_BITS) ? ROW_BITS + 1 : ADDR_BITS;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [ADDR_BITS-1:0]  addr_reg,  addr_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  last_reg;

    logic [COL_BITS-1:0]   col_off;
    logic [ROW_BITS-1:0]   row_off;
    logic [SUM_BITS-1:0]   sum;
    logic                  take;

    assign pix_ready = !out_valid_reg || pixel.ready;
    assign take      = pix_valid && pix_ready;

    // Row offset and format decode
    assign row_off = ROW_BITS'(pix_y) * ROW_BITS'(stride);

    always_comb
    begin
        case (format)
            FMT_RGB565:
            begin
                col_off    = COL_BITS'({pix_x, 1'b0});
                count_next = BYTES_RGB565;
                value_next = VALUE_BITS'({color.red[7:3], color.green[7:2], color.blue[7:3]});
            end
            FMT_RGB888:
            begin
                col_off    = COL_BITS'({pix_x, 1'b0}) + COL_BITS'(pix_x);
                count_next = BYTES_RGB888;
                value_next = {color.red, color.green, color.blue};
            end
            FMT_XRGB8888:
            begin
                col_off    = {pix_x, 2'b00};
                count_next = BYTES_XRGB8888;
                value_next = {color.red, color.green, color.blue};
            end
            default:
            begin
                col_off    = '0;
                count_next = BYTES_NONE;
                value_next = '0;
            end
        endcase
    end

    // Byte address, wrapped; zero when nothing is written
    assign sum       = SUM_BITS'(row_off) + SUM_BITS'(col_off);
    assign addr_next = (count_next == BYTES_NONE) ? '0 : sum[ADDR_BITS-1:0];

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pix_ready)
            out_valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg     <= pix_x;
            y_reg     <= pix_y;
            addr_reg  <= addr_next;
            value_reg <= value_next;
            count_reg <= count_next;
            last_reg  <= pix_last;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_x      = x_reg;
    assign pixel.pixel_y      = y_reg;
    assign pixel.byte_address = addr_reg;
    assign pixel.pixel_value  = value_reg;
    assign pixel.byte_count   = count_reg;
    assign pixel.last_pixel   = last_reg;

endmodule

FILE: rtl/core/line_rasterizer_with_fb_address_top.sv
// Path: a step request's pixel passes the input register, the pixel register
// and the output register, and any of them holds it while the output stalls.
// Throughput: one request per cycle while the pixel output is not stalled;
// the Bresenham state update is made as a request leaves the input register.
// Reset: rst_n clears all valid flags and the line state and restores the
// configuration registers to their reset values; the block is ready at once.
// ----------------------------------------------------------------------------
// line_rasterizer_with_fb_address_top: Bresenham line rasterizer
// Generates line pixels with framebuffer byte address, packed color and byte
// count, configured through an APB-style register port.
// ----------------------------------------------------------------------------
module line_rasterizer_with_fb_address_top #(
    parameter int COORD_BITS  = lrfb_pkg::COORD_BITS_DEF,
    parameter int STRIDE_BITS = lrfb_pkg::STRIDE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lrfb_pkg::PADDR_BITS-1:0] paddr,
    input  logic [lrfb_pkg::PDATA_BITS-1:0] pwdata,
    output logic [lrfb_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready,
    lrfb_draw_if.sink                       draw,
    lrfb_pixel_if.source                    pixel
);
    import lrfb_pkg::*;

    fmt_t                   format;
    logic [STRIDE_BITS-1:0] stride;
    color_t                 color;

    logic                  pix_valid;
    logic                  pix_ready;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic                  pix_last;

    // Configuration registers
    lrfb_regs #(
        .STRIDE_BITS (STRIDE_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .format  (format),
        .stride  (stride),
        .color   (color)
    );

    // Line setup and stepping
    lrfb_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .draw      (draw),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_last  (pix_last)
    );

    // Framebuffer write forming
    lrfb_writer #(
        .COORD_BITS  (COORD_BITS),
        .STRIDE_BITS (STRIDE_BITS)
    ) u_writer (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_last  (pix_last),
        .format    (format),
        .stride    (stride),
        .color     (color),
        .pixel     (pixel)
    );

endmodule
